@@ rtl/crc16_framed_packet_parser_unit_macros.svh @@
// Assertion macros for the frame parser datapath.
`ifndef CRC16_FRAMED_PACKET_PARSER_UNIT_MACROS_SVH
`define CRC16_FRAMED_PACKET_PARSER_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/crc16fp_pkg.sv @@
// Shared types, constants and CRC helper for the frame parser.
`default_nettype none

package crc16fp_pkg;

  localparam int MaxPayload = 64;
  localparam int PayIdxW    = $clog2(MaxPayload);
  localparam int LenW       = 7;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [2:0] {
    ST_BUSY = 3'd0,
    ST_OK   = 3'd1,
    ST_HDR  = 3'd2,
    ST_LEN  = 3'd3,
    ST_CRC  = 3'd4,
    ST_TAIL = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_FIRST_HDR  = 2'd0,
    REG_SECOND_HDR = 2'd1,
    REG_END_MARKER = 2'd2,
    REG_LEN_LIMIT  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]      first_header;
    logic [7:0]      second_header;
    logic [7:0]      end_marker;
    logic [LenW-1:0] length_limit;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    clear;      // reset frame state
    logic    crc_start;  // crc = feed(init, byte)
    logic    crc_feed;   // crc = feed(crc, byte)
    logic    len_load;   // latch length byte
    logic    data_store; // write payload byte, bump count
    logic    crc_lo;     // latch received crc low byte
    logic    crc_hi;     // merge received crc high byte
    logic    res_load;   // load a status item
    logic    res_crc;    // status item carries the received crc
    status_e status;
    logic    emit_rd;    // read payload entry
    logic    emit_wr;    // load payload item from read data
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic eq_first;
    logic eq_second;
    logic eq_end;
    logic len_over;
    logic len_zero_in;
    logic data_done;
    logic low_seen;
    logic crc_match;
    logic frame_empty;
    logic emit_last;
    logic out_free;
  } stat_t;

  // Feed one byte into a reflected CRC16.
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/crc16fp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module crc16fp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/crc16fp_ctrl.sv @@
// Frame parser controller: phase state machine and payload emit sequencer.
`default_nettype none

module crc16fp_ctrl
  import crc16fp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_HEAD1   = 8'b0000_0001,
    S_HEAD2   = 8'b0000_0010,
    S_LEN     = 8'b0000_0100,
    S_DATA    = 8'b0000_1000,
    S_CRC     = 8'b0001_0000,
    S_TAIL    = 8'b0010_0000,
    S_EMIT_RD = 8'b0100_0000,
    S_EMIT_WR = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   parsing;
  logic   accept;

  // Take a byte only in a parse phase with room in the output register.
  assign parsing = (state_q != S_EMIT_RD) && (state_q != S_EMIT_WR);
  assign in_ready_o = parsing && stat_i.out_free;
  assign accept = in_valid_i && in_ready_o;

  // Decode phase and byte into datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.status = ST_BUSY;
    unique case (state_q)
      S_HEAD1: begin
        if (accept) begin
          cmd_o.res_load = 1'b1;
          if (stat_i.eq_first) begin
            cmd_o.crc_start = 1'b1;
            state_d = S_HEAD2;
          end
        end
      end
      S_HEAD2: begin
        if (accept) begin
          cmd_o.res_load = 1'b1;
          if (!stat_i.eq_second) begin
            cmd_o.clear = 1'b1;
            cmd_o.status = ST_HDR;
            if (stat_i.eq_first) begin
              cmd_o.crc_start = 1'b1;
              state_d = S_HEAD2;
            end else begin
              state_d = S_HEAD1;
            end
          end else begin
            cmd_o.crc_feed = 1'b1;
            state_d = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd_o.res_load = 1'b1;
          if (stat_i.len_over) begin
            cmd_o.clear = 1'b1;
            cmd_o.status = ST_LEN;
            state_d = S_HEAD1;
          end else begin
            cmd_o.len_load = 1'b1;
            cmd_o.crc_feed = 1'b1;
            state_d = stat_i.len_zero_in ? S_CRC : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd_o.res_load = 1'b1;
          cmd_o.data_store = 1'b1;
          cmd_o.crc_feed = 1'b1;
          if (stat_i.data_done) begin
            state_d = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (accept) begin
          cmd_o.res_load = 1'b1;
          if (!stat_i.low_seen) begin
            cmd_o.crc_lo = 1'b1;
          end else if (!stat_i.crc_match) begin
            cmd_o.clear = 1'b1;
            cmd_o.status = ST_CRC;
            state_d = S_HEAD1;
          end else begin
            cmd_o.crc_hi = 1'b1;
            state_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (accept) begin
          if (!stat_i.eq_end) begin
            cmd_o.res_load = 1'b1;
            cmd_o.clear = 1'b1;
            cmd_o.status = ST_TAIL;
            state_d = S_HEAD1;
          end else if (stat_i.frame_empty) begin
            // Empty frame: one ok item with the crc, no payload.
            cmd_o.res_load = 1'b1;
            cmd_o.res_crc = 1'b1;
            cmd_o.clear = 1'b1;
            cmd_o.status = ST_OK;
            state_d = S_HEAD1;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        // Read the next entry once the output register can take it.
        if (stat_i.out_free) begin
          cmd_o.emit_rd = 1'b1;
          state_d = S_EMIT_WR;
        end
      end
      S_EMIT_WR: begin
        cmd_o.emit_wr = 1'b1;
        if (stat_i.emit_last) begin
          cmd_o.clear = 1'b1;
          state_d = S_HEAD1;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      default: begin
        cmd_o.clear = 1'b1;
        state_d = S_HEAD1;
      end
    endcase
  end

  // Advance state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEAD1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/crc16fp_dp.sv @@
// Frame parser datapath: CRC, frame counters, payload store and output register.
`default_nettype none

`include "crc16_framed_packet_parser_unit_macros.svh"

module crc16fp_dp
  import crc16fp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cmd_t       cmd_i,
  output stat_t           stat_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output logic [2:0]      parse_status_o,
  output logic [7:0]      payload_byte_o,
  output logic [5:0]      payload_index_o,
  output logic [6:0]      frame_length_o,
  output logic [15:0]     frame_crc_o,
  output logic            payload_valid_o,
  output logic            last_o
);

  logic [15:0]        crc_q, crc_d;
  logic [LenW-1:0]    exp_len_q, exp_len_d;
  logic [LenW-1:0]    count_q, count_d;
  logic               low_seen_q, low_seen_d;
  logic [15:0]        rcrc_q, rcrc_d;
  logic [PayIdxW-1:0] emit_idx_q, emit_idx_d;
  logic [LenW-1:0]    lim;
  logic [LenW-1:0]    count_inc;
  logic [LenW-1:0]    emit_next;
  logic [7:0]         rdata;
  logic               out_valid_q, out_valid_d;
  logic [2:0]         status_q;
  logic [7:0]         pbyte_q;
  logic [5:0]         pidx_q;
  logic [6:0]         flen_q;
  logic [15:0]        fcrc_q;
  logic               pvalid_q;
  logic               last_q;

  // Clamp the length limit to the store depth.
  assign lim = (cfg_i.length_limit > LenW'(MaxPayload)) ? LenW'(MaxPayload)
                                                        : cfg_i.length_limit;
  assign count_inc = count_q + LenW'(1);
  assign emit_next = {1'b0, emit_idx_q} + LenW'(1);

  // Report byte compares and frame progress.
  always_comb begin
    stat_o.eq_first    = (rx_byte_i == cfg_i.first_header);
    stat_o.eq_second   = (rx_byte_i == cfg_i.second_header);
    stat_o.eq_end      = (rx_byte_i == cfg_i.end_marker);
    stat_o.len_over    = (rx_byte_i > {1'b0, lim});
    stat_o.len_zero_in = (rx_byte_i == 8'h00);
    stat_o.data_done   = (count_inc >= exp_len_q);
    stat_o.low_seen    = low_seen_q;
    stat_o.crc_match   = ({rx_byte_i, rcrc_q[7:0]} == crc_q);
    stat_o.frame_empty = (exp_len_q == '0);
    stat_o.emit_last   = (emit_next == exp_len_q);
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Update frame state.
  always_comb begin
    crc_d      = crc_q;
    exp_len_d  = exp_len_q;
    count_d    = count_q;
    low_seen_d = low_seen_q;
    rcrc_d     = rcrc_q;
    emit_idx_d = emit_idx_q;
    if (cmd_i.crc_feed) begin
      crc_d = crc16_feed(crc_q, rx_byte_i);
    end
    if (cmd_i.len_load) begin
      exp_len_d  = rx_byte_i[LenW-1:0];
      count_d    = '0;
      low_seen_d = 1'b0;
      rcrc_d     = '0;
      emit_idx_d = '0;
    end
    if (cmd_i.data_store) begin
      count_d = count_inc;
    end
    if (cmd_i.crc_lo) begin
      rcrc_d     = {8'h00, rx_byte_i};
      low_seen_d = 1'b1;
    end
    if (cmd_i.crc_hi) begin
      rcrc_d = rcrc_q | {rx_byte_i, 8'h00};
    end
    if (cmd_i.emit_wr) begin
      emit_idx_d = emit_next[PayIdxW-1:0];
    end
    if (cmd_i.clear) begin
      crc_d      = CrcInit;
      exp_len_d  = '0;
      count_d    = '0;
      low_seen_d = 1'b0;
      rcrc_d     = '0;
      emit_idx_d = '0;
    end
    if (cmd_i.crc_start) begin
      crc_d = crc16_feed(CrcInit, rx_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      exp_len_q  <= '0;
      count_q    <= '0;
      low_seen_q <= 1'b0;
      rcrc_q     <= '0;
      emit_idx_q <= '0;
    end else begin
      crc_q      <= crc_d;
      exp_len_q  <= exp_len_d;
      count_q    <= count_d;
      low_seen_q <= low_seen_d;
      rcrc_q     <= rcrc_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  // Payload store.
  crc16fp_ram #(
    .Width(8),
    .Depth(MaxPayload)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.data_store),
    .waddr_i(count_q[PayIdxW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.emit_rd),
    .raddr_i(emit_idx_q),
    .rdata_o(rdata)
  );

  // Output register: set on load, drop when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.res_load || cmd_i.emit_wr) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the item fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= cmd_i.status;
      pbyte_q  <= '0;
      pidx_q   <= '0;
      flen_q   <= '0;
      fcrc_q   <= cmd_i.res_crc ? rcrc_q : 16'h0000;
      pvalid_q <= 1'b0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_wr) begin
      status_q <= ST_OK;
      pbyte_q  <= rdata;
      pidx_q   <= emit_idx_q;
      flen_q   <= exp_len_q;
      fcrc_q   <= rcrc_q;
      pvalid_q <= 1'b1;
      last_q   <= stat_o.emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign parse_status_o  = status_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign frame_length_o  = flen_q;
  assign frame_crc_o     = fcrc_q;
  assign payload_valid_o = pvalid_q;
  assign last_o          = last_q;

  `CFP_ASSERT_NOW(a_emit_into_empty, cmd_i.emit_wr, !out_valid_q,
                  "payload item loaded over a pending item")
  `CFP_ASSERT_NOW(a_store_in_range, cmd_i.data_store, count_q < LenW'(MaxPayload),
                  "payload write beyond the store")
  `CFP_ASSERT_NEXT(a_read_then_load, cmd_i.emit_rd, cmd_i.emit_wr,
                   "store read not followed by an item load")

endmodule

`default_nettype wire

@@ rtl/crc16_framed_packet_parser_unit.sv @@
// A status item is in the output register in the cycle after its byte is taken.
// A good frame of n payload bytes emits its items after the tail byte, each by a store read,
// then an output register load; each read waits until the output register is free.
// Throughput: one byte per cycle while items are taken; no bytes taken during emit.
// Reset: asynchronous, active low; parser state and control registers return to defaults;
// the item field registers and the payload store are not cleared (no clearing pass needed).
`default_nettype none

module crc16_framed_packet_parser_unit
  import crc16fp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [2:0]  parse_status_o,
  output logic      [7:0]  payload_byte_o,
  output logic      [5:0]  payload_index_o,
  output logic      [6:0]  frame_length_o,
  output logic      [15:0] frame_crc_o,
  output logic             payload_valid_o,
  output logic             last_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;
  cmd_t     cmd;
  stat_t    stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FIRST_HDR:  cfg_d.first_header  = pwdata[7:0];
        REG_SECOND_HDR: cfg_d.second_header = pwdata[7:0];
        REG_END_MARKER: cfg_d.end_marker    = pwdata[7:0];
        REG_LEN_LIMIT:  cfg_d.length_limit  = pwdata[LenW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_header  <= 8'h0F;
      cfg_q.second_header <= 8'hF0;
      cfg_q.end_marker    <= 8'hFF;
      cfg_q.length_limit  <= LenW'(64);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_FIRST_HDR:  prdata = {24'h0, cfg_q.first_header};
      REG_SECOND_HDR: prdata = {24'h0, cfg_q.second_header};
      REG_END_MARKER: prdata = {24'h0, cfg_q.end_marker};
      REG_LEN_LIMIT:  prdata = {{(32 - LenW){1'b0}}, cfg_q.length_limit};
      default:        prdata = '0;
    endcase
  end

  crc16fp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  crc16fp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .parse_status_o (parse_status_o),
    .payload_byte_o (payload_byte_o),
    .payload_index_o(payload_index_o),
    .frame_length_o (frame_length_o),
    .frame_crc_o    (frame_crc_o),
    .payload_valid_o(payload_valid_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
